[rtl/assert_macros.svh]
// Assertion helpers shared by the clock modules. Each one expects clk and
// rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ccal_pkg.sv]
package ccal_pkg;

    typedef logic [1:0] req_code_t;

    localparam req_code_t REQ_TICK  = 2'd0;
    localparam req_code_t REQ_LOAD  = 2'd1;
    localparam req_code_t REQ_CLEAR = 2'd2;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_ALARM_ENABLE = 2'd0;
    localparam cfg_index_t CFG_ALARM_HOUR   = 2'd1;
    localparam cfg_index_t CFG_ALARM_MINUTE = 2'd2;

    localparam int CFG_DATA_W = 6;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } ccal_time_t;

    typedef struct packed {
        logic       enable;
        logic [4:0] hour;
        logic [5:0] minute;
    } alarm_cfg_t;

    localparam logic [5:0] SEC_MAX       = 6'd59;
    localparam logic [5:0] MIN_MAX       = 6'd59;
    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [3:0] MONTH_MAX     = 4'd12;
    localparam logic [3:0] MONTH_FEB     = 4'd2;
    localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

    // Divisibility by 25: multiply by the inverse of 25 modulo 2^16, then the
    // product is at most floor(65535 / 25) exactly for the multiples of 25.
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    localparam ccal_time_t TIME_RESET = '{
        second: 6'd50,
        minute: 6'd59,
        hour:   5'd23,
        day:    5'd24,
        month:  4'd12,
        year:   16'd2024
    };

    localparam alarm_cfg_t ALARM_RESET = '{
        enable: 1'b1,
        hour:   5'd6,
        minute: 6'd0
    };

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        case (month)
            4'd2:                      days = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

[rtl/ccal_req_if.sv]
interface ccal_req_if;
    import ccal_pkg::*;

    logic        valid;
    logic        ready;
    req_code_t   req_type;
    logic        hold;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;

    modport source (
        output valid, req_type, hold, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        input  ready
    );

    modport sink (
        input  valid, req_type, hold, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        output ready
    );
endinterface

[rtl/ccal_rsp_if.sv]
interface ccal_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic        ringing;
    logic        alarm_fired;

    modport source (
        output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
               cur_year, ringing, alarm_fired,
        input  ready
    );

    modport sink (
        input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
               cur_year, ringing, alarm_fired,
        output ready
    );
endinterface

[rtl/ccal_advance.sv]
module ccal_advance (
    input  ccal_pkg::ccal_time_t cur,
    output ccal_pkg::ccal_time_t nxt
);
    import ccal_pkg::*;

    logic [15:0] year_inv;
    logic        div25;
    logic        leap;
    logic [4:0]  month_len;
    logic [5:0]  day_inc;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        day_wrap;
    logic        month_wrap;

    assign year_inv = cur.year * INV25;
    assign div25    = (year_inv <= DIV25_LIMIT);

    // Gregorian rule: divisible by 4, and either not by 100 or also by 400.
    assign leap = (cur.year[1:0] == 2'd0) && (!div25 || (cur.year[3:0] == 4'd0));

    assign month_len = (cur.month == MONTH_FEB && leap) ? FEB_LEAP_DAYS
                                                        : month_days(cur.month);

    assign sec_wrap   = (cur.second >= SEC_MAX);
    assign min_wrap   = (cur.minute >= MIN_MAX);
    assign hour_wrap  = (cur.hour >= HOUR_MAX);
    assign day_inc    = {1'b0, cur.day} + 6'd1;
    assign day_wrap   = (day_inc > {1'b0, month_len});
    assign month_wrap = (cur.month >= MONTH_MAX);

    always_comb
    begin
        nxt = cur;
        nxt.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
        if (sec_wrap)
        begin
            nxt.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
            if (min_wrap)
            begin
                nxt.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
                if (hour_wrap)
                begin
                    nxt.day = day_wrap ? 5'd1 : day_inc[4:0];
                    if (day_wrap)
                    begin
                        nxt.month = month_wrap ? 4'd1 : cur.month + 4'd1;
                        if (month_wrap)
                        begin
                            nxt.year = cur.year + 16'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

[rtl/ccal_core.sv]
`include "assert_macros.svh"

module ccal_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ccal_pkg::req_code_t  req_type,
    input  logic                 hold,
    input  ccal_pkg::ccal_time_t load,
    input  ccal_pkg::alarm_cfg_t alarm,
    output ccal_pkg::ccal_time_t clock_next,
    output logic                 ringing_next,
    output logic                 fired
);
    import ccal_pkg::*;

    ccal_time_t clock_reg;
    logic       ringing_reg;
    ccal_time_t advanced;
    ccal_time_t clamped;

    ccal_advance u_advance (
        .cur (clock_reg),
        .nxt (advanced)
    );

    // Loaded values are forced into range; the day is not checked against
    // the month length and rolls over on the next day carry.
    always_comb
    begin
        clamped.second = (load.second > SEC_MAX) ? SEC_MAX : load.second;
        clamped.minute = (load.minute > MIN_MAX) ? MIN_MAX : load.minute;
        clamped.hour   = (load.hour > HOUR_MAX) ? HOUR_MAX : load.hour;
        clamped.day    = (load.day == 5'd0) ? 5'd1 : load.day;
        clamped.month  = (load.month == 4'd0)     ? 4'd1
                       : (load.month > MONTH_MAX) ? MONTH_MAX
                       :                            load.month;
        clamped.year   = load.year;
    end

    // The alarm compares the time as it stands before this tick advances it.
    assign fired = (req_type == REQ_TICK) && alarm.enable
                && (clock_reg.hour == alarm.hour)
                && (clock_reg.minute == alarm.minute)
                && (clock_reg.second == 6'd0);

    always_comb
    begin
        clock_next   = clock_reg;
        ringing_next = ringing_reg;
        case (req_type)
            REQ_TICK:
            begin
                ringing_next = ringing_reg | fired;
                if (!hold)
                begin
                    clock_next = advanced;
                end
            end
            REQ_LOAD:
            begin
                clock_next = clamped;
            end
            REQ_CLEAR:
            begin
                ringing_next = 1'b0;
            end
            default:
            begin
                clock_next   = clock_reg;
                ringing_next = ringing_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= TIME_RESET;
            ringing_reg <= 1'b0;
        end
        else if (accept)
        begin
            clock_reg   <= clock_next;
            ringing_reg <= ringing_next;
        end
    end

    `ASSERT_NEXT(a_clear_drops_ringing, accept && req_type == REQ_CLEAR, !ringing_reg, "clear request left the alarm ringing")
    `ASSERT_NEXT(a_hold_keeps_time, accept && req_type == REQ_TICK && hold, $stable(clock_reg), "held tick moved the time")

endmodule

[rtl/calendar_clock_with_alarm_top.sv]
// Real-time clock and Gregorian calendar with one daily alarm. Each item on
// req is a one-second tick, a load of time and date, a clear of the ringing
// flag or a no-op; each gives exactly one item on rsp with the time, date and
// ringing flag as they stand afterwards. A tick first compares hour, minute
// and second zero against the alarm registers, then advances unless hold is
// set; leap years follow the current year. The block takes one item per clock
// cycle: the whole update is one level of carry logic plus a 16-bit multiply
// for the leap-year test, between the state registers and the result register,
// and req stays ready while the result register is empty or being drained.
// Alarm registers are written through cfg_we, cfg_index and cfg_data.
`include "assert_macros.svh"

module calendar_clock_with_alarm_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  ccal_pkg::cfg_index_t              cfg_index,
    input  logic [ccal_pkg::CFG_DATA_W-1:0]   cfg_data,
    ccal_req_if.sink                          req,
    ccal_rsp_if.source                        rsp
);
    import ccal_pkg::*;

    alarm_cfg_t alarm_reg;
    ccal_time_t load;
    ccal_time_t clock_next;
    logic       ringing_next;
    logic       core_fired;
    logic       accept;

    logic       rsp_valid_reg;
    ccal_time_t rsp_time_reg;
    logic       rsp_ringing_reg;
    logic       rsp_fired_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg <= ALARM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALARM_ENABLE: alarm_reg.enable <= cfg_data[0];
                CFG_ALARM_HOUR:   alarm_reg.hour   <= cfg_data[4:0];
                CFG_ALARM_MINUTE: alarm_reg.minute <= cfg_data[5:0];
                default:          alarm_reg        <= alarm_reg;
            endcase
        end
    end

    assign load.second = req.load_second;
    assign load.minute = req.load_minute;
    assign load.hour   = req.load_hour;
    assign load.day    = req.load_day;
    assign load.month  = req.load_month;
    assign load.year   = req.load_year;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    ccal_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req.req_type),
        .hold         (req.hold),
        .load         (load),
        .alarm        (alarm_reg),
        .clock_next   (clock_next),
        .ringing_next (ringing_next),
        .fired        (core_fired)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_time_reg    <= clock_next;
            rsp_ringing_reg <= ringing_next;
            rsp_fired_reg   <= core_fired;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.cur_second  = rsp_time_reg.second;
    assign rsp.cur_minute  = rsp_time_reg.minute;
    assign rsp.cur_hour    = rsp_time_reg.hour;
    assign rsp.cur_day     = rsp_time_reg.day;
    assign rsp.cur_month   = rsp_time_reg.month;
    assign rsp.cur_year    = rsp_time_reg.year;
    assign rsp.ringing     = rsp_ringing_reg;
    assign rsp.alarm_fired = rsp_fired_reg;

    `ASSERT_NEXT(a_fire_sets_ringing, accept && core_fired, rsp.valid && rsp.ringing && rsp.alarm_fired, "alarm match did not reach the result")
    `ASSERT_IMPL(a_fired_implies_ringing, rsp.valid && rsp.alarm_fired, rsp.ringing, "alarm fired without ringing")
    `ASSERT_IMPL(a_time_in_range, rsp.valid, rsp.cur_second <= SEC_MAX && rsp.cur_minute <= MIN_MAX && rsp.cur_hour <= HOUR_MAX && rsp.cur_day != 5'd0 && rsp.cur_month != 4'd0 && rsp.cur_month <= MONTH_MAX, "result time out of range")

endmodule

[tb/ccal_clock_checker.sv]
module ccal_clock_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  ccal_pkg::cfg_index_t            cfg_index,
    input  logic [ccal_pkg::CFG_DATA_W-1:0] cfg_data,
    ccal_req_if                             req,
    ccal_rsp_if                             rsp,
    output int                              error_count,
    output int                              outstanding
);
    import ccal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ccal_time_t t;
        logic       ringing;
        logic       fired;
    } clock_reading_t;

    localparam int MONTH_LENGTH [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    ccal_time_t     clock_now;
    logic           ringing_now;
    alarm_cfg_t     alarm_setting;
    clock_reading_t expected_readings [$];
    clock_reading_t oldest;

    function automatic bit is_leap_year(input logic [15:0] year);
        int y;
        y = year;
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input logic [3:0] month, input logic [15:0] year);
        if (month < 1 || month > 12)
            return 31;
        if (month == 2 && is_leap_year(year))
            return 29;
        return MONTH_LENGTH[month];
    endfunction

    // One second forward with carries into the date. The day is bumped in
    // integer arithmetic so that a day past the month length rolls over.
    task automatic advance_one_second();
        int next_day;
        if (clock_now.second < 59)
        begin
            clock_now.second++;
            return;
        end
        clock_now.second = 0;
        if (clock_now.minute < 59)
        begin
            clock_now.minute++;
            return;
        end
        clock_now.minute = 0;
        if (clock_now.hour < 23)
        begin
            clock_now.hour++;
            return;
        end
        clock_now.hour = 0;
        next_day = clock_now.day + 1;
        if (next_day <= days_in_month(clock_now.month, clock_now.year))
        begin
            clock_now.day = 5'(next_day);
            return;
        end
        clock_now.day = 1;
        if (clock_now.month < 12)
        begin
            clock_now.month++;
            return;
        end
        clock_now.month = 1;
        clock_now.year  = clock_now.year + 16'd1;
    endtask

    task automatic apply_request();
        clock_reading_t r;
        r.fired = 1'b0;
        case (req.req_type)
            REQ_TICK:
            begin
                if (alarm_setting.enable && clock_now.hour == alarm_setting.hour &&
                    clock_now.minute == alarm_setting.minute && clock_now.second == 0)
                begin
                    ringing_now = 1'b1;
                    r.fired     = 1'b1;
                end
                if (!req.hold)
                    advance_one_second();
            end
            REQ_LOAD:
            begin
                clock_now.second = (req.load_second > 6'd59) ? 6'd59 : req.load_second;
                clock_now.minute = (req.load_minute > 6'd59) ? 6'd59 : req.load_minute;
                clock_now.hour   = (req.load_hour > 5'd23) ? 5'd23 : req.load_hour;
                clock_now.day    = (req.load_day == 0) ? 5'd1 : req.load_day;
                if (req.load_month == 0)
                    clock_now.month = 4'd1;
                else if (req.load_month > 4'd12)
                    clock_now.month = 4'd12;
                else
                    clock_now.month = req.load_month;
                clock_now.year = req.load_year;
            end
            REQ_CLEAR:
                ringing_now = 1'b0;
            default:
                ;
        endcase
        r.t       = clock_now;
        r.ringing = ringing_now;
        expected_readings.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_now     = '{second: 6'd50, minute: 6'd59, hour: 5'd23, day: 5'd24,
                              month: 4'd12, year: 16'd2024};
            ringing_now   = 1'b0;
            alarm_setting = '{enable: 1'b1, hour: 5'd6, minute: 6'd0};
            expected_readings.delete();
            error_count   = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ALARM_ENABLE: alarm_setting.enable = cfg_data[0];
                    CFG_ALARM_HOUR:   alarm_setting.hour   = cfg_data[4:0];
                    CFG_ALARM_MINUTE: alarm_setting.minute = cfg_data[5:0];
                    default:          ;
                endcase
            end
            if (req.valid && req.ready)
                apply_request();
            if (rsp.valid && rsp.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %0d:%0d:%0d %0d/%0d/%0d ring %0d fired %0d",
                             $time, rsp.cur_hour, rsp.cur_minute, rsp.cur_second, rsp.cur_day,
                             rsp.cur_month, rsp.cur_year, rsp.ringing, rsp.alarm_fired);
                    error_count++;
                end
                else
                begin
                    oldest = expected_readings.pop_front();
                    check_field("second", 16'(oldest.t.second), 16'(rsp.cur_second));
                    check_field("minute", 16'(oldest.t.minute), 16'(rsp.cur_minute));
                    check_field("hour", 16'(oldest.t.hour), 16'(rsp.cur_hour));
                    check_field("day", 16'(oldest.t.day), 16'(rsp.cur_day));
                    check_field("month", 16'(oldest.t.month), 16'(rsp.cur_month));
                    check_field("year", oldest.t.year, rsp.cur_year);
                    check_field("ringing", 16'(oldest.ringing), 16'(rsp.ringing));
                    check_field("alarm_fired", 16'(oldest.fired), 16'(rsp.alarm_fired));
                end
            end
            outstanding = expected_readings.size();
        end
    end

endmodule

[tb/testbench.sv]
module testbench;
    import ccal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam req_code_t REQ_UNUSED   = 2'd3;
    localparam int        CYCLE_LIMIT  = 600000;
    localparam int        PHASE_ITEMS  = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccal_req_if req ();
    ccal_rsp_if rsp ();

    int failures;
    int pending_readings;
    int items_sent;
    int cycle_count;
    bit steady;

    logic       alarm_on;
    logic [4:0] alarm_h;
    logic [5:0] alarm_m;

    logic [15:0] notable_years [0:8] = '{16'd0, 16'd4, 16'd100, 16'd1900, 16'd2000,
                                         16'd2023, 16'd2024, 16'd2100, 16'd65535};

    calendar_clock_with_alarm_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    ccal_clock_checker watcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .rsp         (rsp),
        .error_count (failures),
        .outstanding (pending_readings)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ccal_time_t time_of(input int s, input int m, input int h,
                                           input int d, input int mo, input int y);
        ccal_time_t t;
        t.second = 6'(s);
        t.minute = 6'(m);
        t.hour   = 5'(h);
        t.day    = 5'(d);
        t.month  = 4'(mo);
        t.year   = 16'(y);
        return t;
    endfunction

    function automatic ccal_time_t any_time();
        return time_of($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 65535));
    endfunction

    // Time and date close to a day, month or year rollover.
    function automatic ccal_time_t near_rollover();
        ccal_time_t t;
        t.second = 6'($urandom_range(50, 59));
        t.minute = ($urandom_range(0, 3) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
        t.hour   = ($urandom_range(0, 3) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
        t.day    = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(26, 31))
                                               : 5'($urandom_range(1, 31));
        t.month  = 4'($urandom_range(1, 12));
        t.year   = ($urandom_range(0, 2) != 0) ? notable_years[$urandom_range(0, 8)]
                                               : 16'($urandom_range(0, 65535));
        return t;
    endfunction

    task automatic send(input req_code_t kind, input logic hold_bit, input ccal_time_t v);
        int gap;
        req.valid       <= 1'b1;
        req.req_type    <= kind;
        req.hold        <= hold_bit;
        req.load_second <= v.second;
        req.load_minute <= v.minute;
        req.load_hour   <= v.hour;
        req.load_day    <= v.day;
        req.load_month  <= v.month;
        req.load_year   <= v.year;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        gap = steady ? 0 : pause_len();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tick(input logic hold_bit);
        send(REQ_TICK, hold_bit, any_time());
    endtask

    task automatic load(input ccal_time_t t);
        send(REQ_LOAD, 1'($urandom_range(0, 1)), t);
    endtask

    // Let every expected result drain before the alarm registers change.
    task automatic settle();
        req.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_readings != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_alarm(input logic en, input logic [5:0] h, input logic [5:0] m);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ALARM_ENABLE;
        cfg_data  <= {5'($urandom_range(0, 31)), en};
        @(posedge clk);
        cfg_index <= CFG_ALARM_HOUR;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= CFG_ALARM_MINUTE;
        cfg_data  <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        alarm_on = en;
        alarm_h  = h[4:0];
        alarm_m  = m;
    endtask

    task automatic calendar_run();
        int n;
        if ($urandom_range(0, 9) < 7)
            load(($urandom_range(0, 9) == 0) ? any_time() : near_rollover());
        n = $urandom_range(2, 15);
        repeat (n) tick($urandom_range(0, 9) == 0);
    endtask

    // Load a time at or just short of the alarm, then tick through it with
    // an occasional hold or clear thrown in.
    task automatic alarm_run();
        ccal_time_t t;
        int n;
        int r;
        t = near_rollover();
        t.hour   = alarm_h;
        t.minute = alarm_m;
        t.second = 0;
        if ($urandom_range(0, 1) == 1)
        begin
            t.second = 6'($urandom_range(55, 59));
            if (alarm_m == 0)
            begin
                t.minute = 59;
                t.hour   = (alarm_h == 0) ? 5'd23 : alarm_h - 5'd1;
            end
            else
                t.minute = alarm_m - 6'd1;
        end
        load(t);
        n = $urandom_range(2, 10);
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                send(REQ_CLEAR, 1'($urandom_range(0, 1)), any_time());
            else
                tick(r <= 2);
        end
        if ($urandom_range(0, 1) == 1)
            send(REQ_CLEAR, 1'($urandom_range(0, 1)), any_time());
    endtask

    task automatic noise_run();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) send(req_code_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), any_time());
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b0;
                repeat (pause_len() + 1) @(posedge clk);
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int phase;
        int phase_end;
        int pick;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_ALARM_ENABLE;
        cfg_data        = '0;
        req.valid       = 1'b0;
        req.req_type    = REQ_TICK;
        req.hold        = 1'b0;
        req.load_second = '0;
        req.load_minute = '0;
        req.load_hour   = '0;
        req.load_day    = '0;
        req.load_month  = '0;
        req.load_year   = '0;
        items_sent      = 0;
        cycle_count     = 0;
        steady          = 1'b0;
        alarm_on        = 1'b1;
        alarm_h         = 5'd6;
        alarm_m         = 6'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ticks from the reset state, year wrap, leap-year rules,
        // a day beyond the month length, clamped loads, the alarm with and
        // without hold, clear, and the unused request code.
        tick(1'b0);
        tick(1'b1);
        load(time_of(59, 59, 23, 31, 12, 65535));
        tick(1'b0);
        load(time_of(59, 59, 23, 28, 2, 0));
        tick(1'b0);
        load(time_of(59, 59, 23, 29, 2, 2000));
        tick(1'b0);
        load(time_of(59, 59, 23, 28, 2, 1900));
        tick(1'b0);
        load(time_of(59, 59, 23, 28, 2, 2023));
        tick(1'b0);
        load(time_of(59, 59, 23, 31, 4, 2024));
        tick(1'b0);
        load(time_of(63, 63, 31, 0, 0, 65535));
        load(time_of(0, 0, 0, 31, 15, 0));
        tick(1'b0);
        load(time_of(59, 59, 5, 1, 1, 2024));
        tick(1'b0);
        tick(1'b0);
        load(time_of(0, 0, 6, 1, 1, 2024));
        tick(1'b1);
        tick(1'b1);
        send(REQ_CLEAR, 1'b1, any_time());
        send(REQ_UNUSED, 1'b0, any_time());

        phase_end = items_sent;
        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                1: set_alarm(1'b1, 6'd0, 6'd0);
                2: set_alarm(1'b1, 6'd23, 6'd59);
                3: set_alarm(1'b0, 6'd12, 6'd30);
                4: set_alarm(1'b1, 6'd63, 6'd63);
                5: set_alarm(1'b1, 6'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
                6: set_alarm(1'b1, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 59)));
                default: ;
            endcase
            phase_end += PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                steady = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    calendar_run();
                else if (pick < 80)
                    alarm_run();
                else
                    noise_run();
            end
        end

        steady = 1'b0;
        settle();
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
